// File: src/tet4_element_stiffness_macros.svh
// Assertion macros for the tetrahedron stiffness block
`ifndef TET4_ELEMENT_STIFFNESS_MACROS_SVH
`define TET4_ELEMENT_STIFFNESS_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// File: src/tet4_pkg.sv
// Shared types and constants for the tetrahedron stiffness block
package tet4_pkg;
  localparam int CoordFracBits = 16;
  localparam int ValueWidth = 48;
  localparam int OutFracBits = 16;
  localparam int CfgWidth = 32;
  localparam int WideW = 256;
  localparam logic [0:0] CfgYoung = 1'b0;
  localparam logic [0:0] CfgPoisson = 1'b1;

  typedef logic signed [WideW-1:0] wide_t;

  typedef enum logic [3:0] {
    ST_COLLECT, ST_EDGE, ST_GRAD, ST_DET, ST_DEN, ST_DOT, ST_NUM,
    ST_DIV_START, ST_DIV_WAIT, ST_EMIT, ST_OUT
  } state_t;

  // Multiplier job toward the shared unit
  typedef struct packed {
    logic start;
    wide_t a;
    wide_t b;
  } mul_req_t;

  typedef struct packed {
    logic done;
    wide_t p;
  } mul_rsp_t;
endpackage

// File: src/tet4_if.sv
// Valid/ready channel interfaces for input nodes and output blocks
interface tet4_in_if (input logic clk);
  logic valid;
  logic ready;
  logic signed [31:0] x;
  logic signed [31:0] y;
  logic signed [31:0] z;
  modport source (output valid, x, y, z, input ready);
  modport sink (input valid, x, y, z, output ready);
endinterface

interface tet4_out_if (input logic clk);
  logic valid;
  logic ready;
  logic [3:0] block;
  logic signed [47:0] k00;
  logic signed [47:0] k01;
  logic signed [47:0] k02;
  logic signed [47:0] k10;
  logic signed [47:0] k11;
  logic signed [47:0] k12;
  logic signed [47:0] k20;
  logic signed [47:0] k21;
  logic signed [47:0] k22;
  logic degenerate;
  logic last;
  modport source (output valid, block, k00, k01, k02, k10, k11, k12, k20, k21, k22,
    degenerate, last, input ready);
  modport sink (input valid, block, k00, k01, k02, k10, k11, k12, k20, k21, k22,
    degenerate, last, output ready);
endinterface

// File: src/tet4_mul.sv
// Shared signed multiplier: 32x32 partial product per cycle, magnitude form
module tet4_mul (
  input  logic clk,
  input  logic rst,
  input  tet4_pkg::mul_req_t req,
  output tet4_pkg::mul_rsp_t rsp
);
  import tet4_pkg::*;
  localparam int Limbs = WideW / 32;
  localparam int CntW = $clog2(Limbs * Limbs + 1);

  logic busy;
  logic neg;
  logic [WideW-1:0] ma;
  logic [WideW-1:0] mb;
  logic [WideW-1:0] acc;
  logic [CntW-1:0] ia;
  logic [CntW-1:0] ib;
  logic [63:0] pp;
  logic [WideW-1:0] pp_sh;
  logic [WideW-1:0] ma_in;
  logic [WideW-1:0] mb_in;

  assign ma_in = req.a[WideW-1] ? WideW'(-req.a) : req.a;
  assign mb_in = req.b[WideW-1] ? WideW'(-req.b) : req.b;
  assign pp = 64'(ma[ia[2:0]*32 +: 32]) * 64'(mb[ib[2:0]*32 +: 32]);
  assign pp_sh = WideW'({192'd0, pp}) << ((ia[2:0] + ib[2:0]) * 32);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        ma <= ma_in;
        mb <= mb_in;
        neg <= req.a[WideW-1] ^ req.b[WideW-1];
        acc <= '0;
        ia <= '0;
        ib <= '0;
      end else if (busy) begin
        acc <= acc + pp_sh;
        if (ib == CntW'(Limbs - 1)) begin
          ib <= '0;
          if (ia == CntW'(Limbs - 1)) begin
            busy <= 1'b0;
            rsp.done <= 1'b1;
            rsp.p <= neg ? wide_t'(-(acc + pp_sh)) : wide_t'(acc + pp_sh);
          end else begin
            ia <= ia + 1'b1;
          end
        end else begin
          ib <= ib + 1'b1;
        end
      end
    end
  end
endmodule

// File: src/tet4_div.sv
// Shared restoring divider: one quotient bit per cycle, round half up
module tet4_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [tet4_pkg::WideW-1:0] num,
  input  logic [tet4_pkg::WideW-1:0] den,
  output logic done,
  output logic [tet4_pkg::WideW-1:0] quo
);
  import tet4_pkg::*;
  localparam int CntW = $clog2(WideW + 1);

  logic busy;
  logic [CntW-1:0] cnt;
  logic [WideW-1:0] n;
  logic [WideW-1:0] d;
  logic [WideW:0] r;
  logic [WideW:0] r_sh;
  logic [WideW:0] r_fin;

  assign r_sh = {r[WideW-1:0], n[WideW-1]};
  assign r_fin = {r[WideW-1:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        n <= num;
        d <= den;
        r <= '0;
        quo <= '0;
        cnt <= CntW'(WideW);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
          if (r_fin >= {1'b0, d}) quo <= quo + 1'b1;
        end else begin
          n <= n << 1;
          cnt <= cnt - 1'b1;
          if (r_sh >= {1'b0, d}) begin
            r <= r_sh - {1'b0, d};
            quo <= {quo[WideW-2:0], 1'b1};
          end else begin
            r <= r_sh;
            quo <= {quo[WideW-2:0], 1'b0};
          end
        end
      end
    end
  end

  `include "tet4_element_stiffness_macros.svh"
  `ASSERT_NEVER(a_div_start_busy, clk, rst, start && busy)
  `ASSERT_IMPL(a_div_done_pulse, clk, rst, done |=> !done)
  `ASSERT_IMPL(a_div_done_after_busy, clk, rst, done |-> $past(busy))
endmodule

// File: src/tet4_element_stiffness.sv
// Tetrahedron element stiffness: node intake, sequencer, shared mul/div units
// Each 256 bit product runs as 32x32 partial products on the shared multiplier;
//   each entry needs six products and a divide, and the products dominate.
// Nodes are taken only while collecting; the next element waits for the last block.
// Reset: synchronous; clears node count and sequencer, registers to defaults.
module tet4_element_stiffness (
  input  logic clk,
  input  logic rst,
  tet4_in_if.sink in_ch,
  tet4_out_if.source out_ch,
  input  logic cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [tet4_pkg::CfgWidth-1:0] cfg_data
);
  import tet4_pkg::*;

  logic [31:0] young;
  logic [14:0] poisson;
  logic [1:0] loaded;
  logic signed [31:0] cs [12];
  logic signed [33:0] e [9];
  wide_t g [12];
  wide_t det;
  wide_t den;
  wide_t dot;
  wide_t av;
  wide_t bv;
  wide_t acc;
  wide_t tmp;
  logic degen;
  state_t state;
  state_t state_next;
  logic [3:0] step;
  logic [3:0] blk;
  logic [3:0] ent;
  logic [1:0] ea;
  logic [1:0] eb;
  logic [1:0] bi;
  logic [1:0] bj;
  logic signed [ValueWidth-1:0] kv [9];
  mul_req_t mreq;
  mul_rsp_t mrsp;
  logic dstart;
  logic ddone;
  logic [WideW-1:0] dnum;
  logic [WideW-1:0] dquo;
  logic mwait;
  logic [ValueWidth-1:0] sat;
  logic [ValueWidth-2:0] maxpos;

  tet4_mul u_mul (.clk, .rst, .req(mreq), .rsp(mrsp));
  tet4_div u_div (.clk, .rst, .start(dstart), .num(dnum), .den(den[WideW-1:0]),
    .done(ddone), .quo(dquo));

  assign bi = blk[3:2];
  assign bj = blk[1:0];
  assign maxpos = '1;

  always_comb begin
    if (acc[WideW-1]) begin
      if (dquo > WideW'({1'b1, {(ValueWidth-1){1'b0}}}))
        sat = {1'b1, {(ValueWidth-1){1'b0}}};
      else sat = ValueWidth'(-dquo);
    end else begin
      if (dquo > WideW'(maxpos)) sat = {1'b0, maxpos};
      else sat = dquo[ValueWidth-1:0];
    end
  end

  // Gradient terms: gvec picks the cross product, step[2:1] the component, step[0] the half
  logic [1:0] gvec;
  logic [1:0] gc;
  logic [1:0] pa;
  logic [1:0] pb;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_COLLECT;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_COLLECT: if (in_ch.valid && loaded == 2'd3) state_next = ST_EDGE;
      ST_EDGE: state_next = ST_GRAD;
      ST_GRAD: if (mrsp.done && step == 4'd5 && gvec == 2'd2) state_next = ST_DET;
      ST_DET: if (mrsp.done && step == 4'd2)
        state_next = ((acc + mrsp.p) == '0) ? ST_OUT : ST_DEN;
      ST_DEN: if (mrsp.done && step == 4'd1) state_next = ST_DOT;
      ST_DOT: if (mrsp.done && step == 4'd2) state_next = ST_NUM;
      ST_NUM: if (mrsp.done && step == 4'd5) state_next = ST_DIV_START;
      ST_DIV_START: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: if (ddone) state_next = ST_EMIT;
      ST_EMIT: state_next = (ent == 4'd8) ? ST_OUT : ST_NUM;
      ST_OUT: if (out_ch.ready) state_next = (blk == 4'd15) ? ST_COLLECT :
        (degen ? ST_OUT : ST_DOT);
      default: state_next = ST_COLLECT;
    endcase
  end

  assign in_ch.ready = (state == ST_COLLECT);
  assign dstart = (state == ST_DIV_START);
  assign out_ch.valid = (state == ST_OUT);
  assign out_ch.block = blk;
  assign out_ch.degenerate = degen;
  assign out_ch.last = (blk == 4'd15);
  assign out_ch.k00 = kv[0];
  assign out_ch.k01 = kv[1];
  assign out_ch.k02 = kv[2];
  assign out_ch.k10 = kv[3];
  assign out_ch.k11 = kv[4];
  assign out_ch.k12 = kv[5];
  assign out_ch.k20 = kv[6];
  assign out_ch.k21 = kv[7];
  assign out_ch.k22 = kv[8];
  assign dnum = WideW'(acc[WideW-1] ? -acc : acc) << OutFracBits;

  function automatic logic [1:0] nx(input logic [1:0] c, input logic [1:0] k);
    logic [2:0] s;
    s = 3'(c) + 3'(k);
    return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
  endfunction

  // gradient store: g1 at 0..2, g2 at 3..5, g3 at 6..8, g0 at 9..11
  function automatic logic [3:0] gidx(input logic [1:0] node, input logic [1:0] comp);
    return (node == 2'd0) ? (4'd9 + 4'(comp)) : (4'(node) * 4'd3 - 4'd3 + 4'(comp));
  endfunction

  assign gc = step[2:1];

  always_comb begin
    // g1=e1xe2, g2=e2xe0, g3=e0xe1 (edge rows 0..2)
    pa = (gvec == 2'd0) ? 2'd1 : ((gvec == 2'd1) ? 2'd2 : 2'd0);
    pb = (gvec == 2'd0) ? 2'd2 : ((gvec == 2'd1) ? 2'd0 : 2'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      young <= 32'd1000;
      poisson <= 15'd19661;
      loaded <= '0;
      mreq.start <= 1'b0;
      mwait <= 1'b0;
    end else begin
      mreq.start <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CfgYoung: young <= cfg_data;
          CfgPoisson: poisson <= cfg_data[14:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        cs[4'(loaded) * 4'd3] <= in_ch.x;
        cs[4'(loaded) * 4'd3 + 4'd1] <= in_ch.y;
        cs[4'(loaded) * 4'd3 + 4'd2] <= in_ch.z;
        loaded <= loaded + 1'b1;
      end
      unique case (state)
        ST_COLLECT: begin
          step <= '0;
          mwait <= 1'b0;
        end
        ST_EDGE: begin
          for (int k = 0; k < 9; k++) e[k] <= 34'(cs[k+3]) - 34'(cs[k%3]);
          step <= '0;
          gvec <= '0;
          mwait <= 1'b0;
          acc <= '0;
        end
        ST_GRAD: begin
          // cross component c: e_pa[c+1]*e_pb[c+2] - e_pa[c+2]*e_pb[c+1]
          if (!mwait) begin
            mreq.start <= 1'b1;
            mwait <= 1'b1;
            mreq.a <= wide_t'(e[4'(pa * 3 + nx(gc, 2'(1 + step[0])))]);
            mreq.b <= wide_t'(e[4'(pb * 3 + nx(gc, 2'(2 - step[0])))]);
          end else if (mrsp.done) begin
            mwait <= 1'b0;
            tmp <= mrsp.p;
            step <= step + 1'b1;
            if (step[0]) g[4'(3 * gvec + gc)] <= tmp - mrsp.p;
            if (step == 4'd5) begin
              step <= '0;
              gvec <= gvec + 1'b1;
              if (gvec == 2'd2) acc <= '0;
            end
          end
        end
        ST_DET: begin
          if (!mwait) begin
            mreq.start <= 1'b1;
            mwait <= 1'b1;
            mreq.a <= wide_t'(e[step]);
            mreq.b <= g[step];
          end else if (mrsp.done) begin
            mwait <= 1'b0;
            acc <= acc + mrsp.p;
            step <= step + 1'b1;
            if (step == 4'd2) begin
              det <= acc + mrsp.p;
              degen <= (acc + mrsp.p) == '0;
              step <= '0;
              blk <= '0;
              for (int k = 0; k < 9; k++) kv[k] <= '0;
            end
          end
        end
        ST_DEN: begin
          if (!mwait) begin
            mreq.start <= 1'b1;
            mwait <= 1'b1;
            if (step == 4'd0) begin
              mreq.a <= wide_t'(18'd65536 + 18'(poisson));
              mreq.b <= wide_t'(6 * (18'd65536 - 18'(2 * 17'(poisson))));
            end else begin
              mreq.a <= tmp;
              mreq.b <= det[WideW-1] ? -det : det;
            end
          end else if (mrsp.done) begin
            mwait <= 1'b0;
            tmp <= mrsp.p;
            step <= step + 1'b1;
            if (step == 4'd1) begin
              den <= mrsp.p << CoordFracBits;
              step <= '0;
              blk <= '0;
              acc <= '0;
              // g0 = -(g1+g2+g3)
              for (int c = 0; c < 3; c++) g[9+c] <= -(g[c] + g[3+c] + g[6+c]);
            end
          end
        end
        ST_DOT: begin
          ent <= '0;
          ea <= '0;
          eb <= '0;
          if (!mwait) begin
            mreq.start <= 1'b1;
            mwait <= 1'b1;
            mreq.a <= g[gidx(bi, step[1:0])];
            mreq.b <= g[gidx(bj, step[1:0])];
          end else if (mrsp.done) begin
            mwait <= 1'b0;
            acc <= (step == 4'd0 ? '0 : acc) + mrsp.p;
            step <= step + 1'b1;
            if (step == 4'd2) begin
              dot <= acc + mrsp.p;
              step <= '0;
            end
          end
        end
        ST_NUM: begin
          // 0: gi[a]gj[b]  1: gi[b]gj[a]  2: Ln*av  3: Mn*bv  4: sum*E (acc)  5: times 1 (acc)
          if (!mwait) begin
            mreq.start <= 1'b1;
            mwait <= 1'b1;
            unique case (step)
              4'd0: begin
                mreq.a <= g[gidx(bi, ea)];
                mreq.b <= g[gidx(bj, eb)];
              end
              4'd1: begin
                mreq.a <= g[gidx(bi, eb)];
                mreq.b <= g[gidx(bj, ea)];
              end
              4'd2: begin
                mreq.a <= wide_t'({poisson, 16'd0});
                mreq.b <= av;
              end
              4'd3: begin
                mreq.a <= wide_t'(33'(32768) * 33'(18'd65536 - 18'(2 * 17'(poisson))));
                mreq.b <= bv;
              end
              4'd4: begin
                mreq.a <= tmp;
                mreq.b <= wide_t'({1'b0, young});
              end
              default: begin
                mreq.a <= tmp;
                mreq.b <= wide_t'(1);
              end
            endcase
          end else if (mrsp.done) begin
            mwait <= 1'b0;
            step <= step + 1'b1;
            unique case (step)
              4'd0: av <= mrsp.p;
              4'd1: bv <= (ea == eb) ? mrsp.p + dot : mrsp.p;
              4'd2: tmp <= mrsp.p;
              4'd3: tmp <= tmp + mrsp.p;
              default: begin
                acc <= mrsp.p;
                tmp <= mrsp.p;
              end
            endcase
            if (step == 4'd5) step <= '0;
          end
        end
        ST_DIV_START, ST_DIV_WAIT: ;
        ST_EMIT: begin
          kv[ent] <= (dquo == '0) ? '0 : sat;
          ent <= ent + 1'b1;
          if (eb == 2'd2) begin
            eb <= '0;
            ea <= ea + 1'b1;
          end else begin
            eb <= eb + 1'b1;
          end
        end
        ST_OUT: begin
          if (out_ch.ready) begin
            blk <= blk + 1'b1;
            step <= '0;
            acc <= '0;
            if (blk == 4'd15) loaded <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  `include "tet4_element_stiffness_macros.svh"
  `ASSERT_IMPL(a_no_take_busy, clk, rst, (state != ST_COLLECT) |-> !in_ch.ready)
  `ASSERT_IMPL(a_out_only_out, clk, rst, out_ch.valid |-> (state == ST_OUT))
  `ASSERT_NEVER(a_mul_overlap, clk, rst, mreq.start && $past(mreq.start))
endmodule

// File: tb/sv/tb.sv
// Testbench for the tetrahedron element stiffness block: directed and random elements
`timescale 1ns / 1ps

module tb;
  typedef logic signed [319:0] bignum_t;
  typedef logic signed [47:0] entry_t;

  typedef struct {
    logic [3:0] block;
    entry_t k[9];
    logic degenerate;
    logic last;
  } stiff_block_t;

  localparam int WatchdogLimit = 600000;
  localparam int DrainCycles = 200;

  logic clk;
  logic rst = 1'b1;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [tet4_pkg::CfgWidth-1:0] cfg_data;

  tet4_in_if in_ch (clk);
  tet4_out_if out_ch (clk);

  tet4_element_stiffness dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // shadow registers and element collection
  logic [31:0] young;
  logic [14:0] poisson;
  logic signed [31:0] corner[4][3];
  int nodes_held;
  stiff_block_t pending_blocks[$];
  int mismatches;
  int idle_count;
  bit quiet;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= WatchdogLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic entry_t round_saturate(bignum_t num, bignum_t den);
    bignum_t mag;
    bignum_t q;
    bignum_t top;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    top = bignum_t'(1) <<< 47;
    if (q == 0) return '0;
    if (num < 0) return (q > top) ? entry_t'(-top) : entry_t'(-q);
    return (q > top - 1) ? entry_t'(top - 1) : entry_t'(q);
  endfunction

  // K = V * B^T D B on exact integers, sixteen node-pair blocks
  function automatic void predict_stiffness();
    bignum_t e[3][3];
    bignum_t g[4][3];
    bignum_t det, den, dot, av, bv, num, n, ln, mn, ym;
    stiff_block_t blk;
    int c1, c2;
    for (int k = 0; k < 3; k++)
      for (int c = 0; c < 3; c++)
        e[k][c] = bignum_t'(corner[k+1][c]) - bignum_t'(corner[0][c]);
    for (int c = 0; c < 3; c++) begin
      c1 = (c + 1) % 3;
      c2 = (c + 2) % 3;
      g[1][c] = e[1][c1] * e[2][c2] - e[1][c2] * e[2][c1];
      g[2][c] = e[2][c1] * e[0][c2] - e[2][c2] * e[0][c1];
      g[3][c] = e[0][c1] * e[1][c2] - e[0][c2] * e[1][c1];
      g[0][c] = -(g[1][c] + g[2][c] + g[3][c]);
    end
    det = 0;
    for (int c = 0; c < 3; c++) det += e[0][c] * g[1][c];
    n = bignum_t'({1'b0, poisson});
    ym = bignum_t'({1'b0, young});
    den = 6 * (65536 + n) * (65536 - 2 * n) * ((det < 0) ? -det : det);
    den = den <<< tet4_pkg::CoordFracBits;
    ln = n <<< 16;
    mn = 32768 * (65536 - 2 * n);
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        blk.block = 4'(i * 4 + j);
        blk.degenerate = (det == 0);
        blk.last = (i == 3 && j == 3);
        dot = g[i][0] * g[j][0] + g[i][1] * g[j][1] + g[i][2] * g[j][2];
        for (int a = 0; a < 3; a++)
          for (int b = 0; b < 3; b++) begin
            if (det == 0) begin
              blk.k[a*3+b] = '0;
            end else begin
              av = g[i][a] * g[j][b];
              bv = g[i][b] * g[j][a];
              if (a == b) bv += dot;
              num = (ym * (ln * av + mn * bv)) <<< tet4_pkg::OutFracBits;
              blk.k[a*3+b] = round_saturate(num, den);
            end
          end
        pending_blocks.push_back(blk);
      end
  endfunction

  task automatic send_node(logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.x <= x;
    in_ch.y <= y;
    in_ch.z <= z;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    corner[nodes_held] = '{x, y, z};
    if (nodes_held == 3) begin
      nodes_held = 0;
      predict_stiffness();
    end else begin
      nodes_held++;
    end
  endtask

  // sender waits out every pending block before touching registers
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == tet4_pkg::CfgYoung) young = value;
    else poisson = value[14:0];
  endtask

  task automatic send_element(logic signed [31:0] pts[4][3]);
    for (int i = 0; i < 4; i++) send_node(pts[i][0], pts[i][1], pts[i][2]);
  endtask

  // one unit edge along each axis from the origin, then an irregular element
  task automatic test_reset_defaults();
    logic signed [31:0] pts[4][3];
    pts = '{'{0, 0, 0}, '{32'sh10000, 0, 0}, '{0, 32'sh10000, 0}, '{0, 0, 32'sh10000}};
    send_element(pts);
    pts = '{'{-32'sh8000, 32'sh3000, 7}, '{32'sh25000, -5, 32'sh1000},
            '{32'sh100, 32'sh40000, -32'sh2000}, '{-32'sh700, 32'sh900, 32'sh33333}};
    send_element(pts);
  endtask

  task automatic test_degenerate();
    logic signed [31:0] pts[4][3];
    pts = '{'{5, 5, 5}, '{5, 5, 5}, '{5, 5, 5}, '{5, 5, 5}};
    send_element(pts);
    // coplanar: fourth corner in the plane of the others
    pts = '{'{0, 0, 0}, '{32'sh10000, 0, 32'sh500}, '{0, 32'sh20000, 32'sh700},
            '{32'sh10000, 32'sh20000, 32'shC00}};
    send_element(pts);
  endtask

  task automatic test_coord_extremes();
    logic signed [31:0] pts[4][3];
    pts = '{'{32'sh80000000, 32'sh80000000, 32'sh80000000},
            '{32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000},
            '{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000},
            '{32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF}};
    send_element(pts);
    // tiny element: one-unit edges, entries stay well inside the output range
    pts = '{'{0, 0, 0}, '{1, 0, 0}, '{0, 1, 0}, '{0, 0, 1}};
    send_element(pts);
  endtask

  task automatic test_modulus_extremes();
    logic signed [31:0] pts[4][3];
    pts = '{'{0, 0, 0}, '{32'sh30000, 0, 0}, '{0, 32'sh10000, 0}, '{0, 0, -32'sh18000}};
    write_reg(tet4_pkg::CfgYoung, 32'd0);
    send_element(pts);
    write_reg(tet4_pkg::CfgYoung, 32'hFFFFFFFF);
    send_element(pts);
  endtask

  task automatic test_poisson_extremes();
    logic signed [31:0] pts[4][3];
    pts = '{'{32'sh100, 0, 0}, '{32'sh50000, 32'sh100, 0}, '{0, 32'sh50000, 32'sh1},
            '{0, 0, 32'sh50000}};
    write_reg(tet4_pkg::CfgYoung, 32'd210000);
    write_reg(tet4_pkg::CfgPoisson, 32'd0);
    send_element(pts);
    write_reg(tet4_pkg::CfgPoisson, 32'd32767);
    send_element(pts);
  endtask

  task automatic test_random_elements(int count);
    logic signed [31:0] pts[4][3];
    int mode;
    for (int el = 0; el < count; el++) begin
      if (el % 8 == 7) begin
        write_reg(tet4_pkg::CfgYoung, $urandom_range(0, 3) == 0 ? $urandom
                                                               : $urandom_range(1, 300000));
        write_reg(tet4_pkg::CfgPoisson, $urandom_range(0, 32767));
      end
      quiet = ($urandom_range(0, 3) == 0);
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 4; i++)
        for (int c = 0; c < 3; c++)
          if (mode >= 8 || i == 0) pts[i][c] = $urandom;
          else pts[i][c] = pts[0][c] + $signed($urandom_range(0, 32'h200000)) - 32'sh100000;
      if (mode == 7)
        for (int c = 0; c < 3; c++) pts[3][c] = pts[1][c] + pts[2][c] - pts[0][c];
      send_element(pts);
    end
    quiet = 1'b0;
  endtask

  // result side: random stalls unless quiet, each block checked against the oldest prediction
  initial begin
    stiff_block_t want;
    entry_t got[9];
    int stall;
    bit bad;
    out_ch.ready <= 1'b0;
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(out_ch.valid && !rst)) @(posedge clk);
      got = '{out_ch.k00, out_ch.k01, out_ch.k02, out_ch.k10, out_ch.k11, out_ch.k12,
              out_ch.k20, out_ch.k21, out_ch.k22};
      if (pending_blocks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected block %0d", out_ch.block);
      end else begin
        want = pending_blocks.pop_front();
        bad = (want.block != out_ch.block) || (want.degenerate != out_ch.degenerate)
              || (want.last != out_ch.last);
        for (int f = 0; f < 9; f++) if (want.k[f] !== got[f]) bad = 1'b1;
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("block mismatch: exp blk=%0d deg=%0b last=%0b got blk=%0d deg=%0b last=%0b",
                     want.block, want.degenerate, want.last, out_ch.block,
                     out_ch.degenerate, out_ch.last);
            for (int f = 0; f < 9; f++)
              $display("  k%0d%0d exp %0d got %0d", f / 3, f % 3, want.k[f], got[f]);
          end
        end
      end
    end
  end

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.x <= '0;
    in_ch.y <= '0;
    in_ch.z <= '0;
    cfg_we <= 1'b0;
    cfg_index <= tet4_pkg::CfgYoung;
    cfg_data <= '0;
    young = 32'd1000;
    poisson = 15'd19661;
    nodes_held = 0;
    mismatches = 0;
    idle_count = 0;
    quiet = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_degenerate();
    test_coord_extremes();
    test_modulus_extremes();
    test_poisson_extremes();
    test_random_elements(42);

    drain();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && pending_blocks.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

// File: filelist.f
+incdir+src
src/tet4_pkg.sv
src/tet4_if.sv
src/tet4_mul.sv
src/tet4_div.sv
src/tet4_element_stiffness.sv
tb/sv/tb.sv
